[src/permutation_min_swap_cost_core_assert.svh]
// Assertion macros for the permutation minimum swap cost core.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef PERMUTATION_MIN_SWAP_COST_CORE_ASSERT_SVH
`define PERMUTATION_MIN_SWAP_COST_CORE_ASSERT_SVH

// same-cycle implication
`define PMSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PMSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pmsc_pkg.sv]
// Package for the permutation minimum swap cost core: word types, widths, helpers.
// No dependencies.
`default_nettype none

package pmsc_pkg;

  localparam int MAX_ELEMENTS = 1024;

  localparam int VAL_W   = 11;
  localparam int SWAPS_W = 10;
  localparam int COST_W  = 21;
  localparam int SUM_W   = 22;

  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int IX_W   = (CNT_W > VAL_W) ? CNT_W : VAL_W;
  localparam int PROD_W = CNT_W + VAL_W;
  localparam int CP_W   = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 2;
  localparam int SWS_W  = ((SWAPS_W > CNT_W) ? SWAPS_W : CNT_W) + 1;
  localparam int COS_W  = ((COST_W > CP_W) ? COST_W : CP_W) + 1;

  localparam logic [SWAPS_W-1:0] SWAPS_MAX = '1;
  localparam logic [COST_W-1:0]  COST_MAX  = '1;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } in_t;

  typedef struct packed {
    logic [SWAPS_W-1:0] min_swaps;
    logic [COST_W-1:0]  min_cost;
  } out_t;

  // position 1..N maps to address 0..N-1
  function automatic logic [ADDR_W-1:0] addr_of(input logic [IX_W-1:0] x);
    logic [IX_W-1:0] t;
    t = x - IX_W'(1);
    return t[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

[src/pmsc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pmsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/permutation_min_swap_cost_core.sv]
// Operation: loading accepts one word per cycle; after the last word, evaluation reads and
// checks each position in turn (scan read, scan check), follows each cycle element by element
// in the walk state, closes the walk in the multiply state, and for a walk that takes an element
// adds the cost and accumulate states; the result is registered from the final state. Input is
// stalled from the last word until the result is issued; the final state waits while an earlier
// result word is stalled. Reset: async active low; visited entries are cleared as each word is loaded.
`default_nettype none

module permutation_min_swap_cost_core
  import pmsc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  typedef enum logic [2:0] {
    S_LOAD, S_SCAN_RD, S_SCAN_CK, S_WALK, S_MUL, S_COST, S_ACC, S_FIN
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    i_q, i_d;
  logic [VAL_W-1:0]    v_q, v_d;
  logic [CNT_W-1:0]    len_q, len_d;
  logic [VAL_W-1:0]    mn_q, mn_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [CP_W-1:0]     cp_q, cp_d;
  logic [SWAPS_W-1:0]  sw_q, sw_d;
  logic [COST_W-1:0]   co_q, co_d;
  logic                byp_vld_q, byp_vld_d;
  logic [ADDR_W-1:0]   byp_addr_q, byp_addr_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_data_q, out_data_d;

  logic                perm_we, vis_we, vis_wdata, rd_en;
  logic [ADDR_W-1:0]   perm_waddr, vis_waddr, raddr;
  logic [VAL_W-1:0]    perm_rdata;
  logic                vis_rdata;

  logic [CNT_W-1:0]    lm1;
  logic [CP_W-1:0]     base, alt;
  logic [SWS_W-1:0]    sw_sum;
  logic [COS_W-1:0]    co_sum;
  logic                stop;

  pmsc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMENTS)) u_perm (
    .clk_i   (clk_i),
    .we_i    (perm_we),
    .waddr_i (perm_waddr),
    .wdata_i (in_data_i.value),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (perm_rdata)
  );

  pmsc_ram #(.WIDTH(1), .DEPTH(MAX_ELEMENTS)) u_vis (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (vis_rdata)
  );

  assign lm1    = len_q - CNT_W'(1);
  assign base   = CP_W'(prod_q) + CP_W'(sum_q) - CP_W'(mn_q);
  assign alt    = CP_W'(sum_q) + CP_W'(mn_q) + CP_W'(len_q) + CP_W'(1);
  assign sw_sum = SWS_W'(sw_q) + SWS_W'(lm1);
  assign co_sum = COS_W'(co_q) + COS_W'(cp_q);
  assign stop   = (v_q == '0) || (IX_W'(v_q) > IX_W'(cnt_q)) || vis_rdata ||
                  (byp_vld_q && (byp_addr_q == addr_of(IX_W'(v_q))));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    v_d         = v_q;
    len_d       = len_q;
    mn_d        = mn_q;
    sum_d       = sum_q;
    prod_d      = prod_q;
    cp_d        = cp_q;
    sw_d        = sw_q;
    co_d        = co_q;
    byp_vld_d   = byp_vld_q;
    byp_addr_d  = byp_addr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    perm_we     = 1'b0;
    perm_waddr  = cnt_q[ADDR_W-1:0];
    vis_we      = 1'b0;
    vis_waddr   = addr_of(IX_W'(i_q));
    vis_wdata   = 1'b1;
    rd_en       = 1'b0;
    raddr       = addr_of(IX_W'(i_q));

    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (cnt_q < CNT_W'(MAX_ELEMENTS)) begin
            cnt_d     = cnt_q + CNT_W'(1);
            perm_we   = 1'b1;
            vis_we    = 1'b1;
            vis_waddr = cnt_q[ADDR_W-1:0];
            vis_wdata = 1'b0;
          end
          if (in_data_i.last) begin
            i_d     = CNT_W'(1);
            sw_d    = '0;
            co_d    = '0;
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        rd_en   = 1'b1;
        state_d = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (vis_rdata || (IX_W'(perm_rdata) == IX_W'(i_q))) begin
          vis_we = !vis_rdata;
          if (i_q == cnt_q) begin
            state_d = S_FIN;
          end else begin
            i_d     = i_q + CNT_W'(1);
            state_d = S_SCAN_RD;
          end
        end else begin
          v_d       = perm_rdata;
          len_d     = '0;
          sum_d     = '0;
          mn_d      = '0;
          byp_vld_d = 1'b0;
          rd_en     = 1'b1;
          raddr     = addr_of(IX_W'(perm_rdata));
          state_d   = S_WALK;
        end
      end
      S_WALK: begin
        if (stop) begin
          byp_vld_d = 1'b0;
          state_d   = S_MUL;
        end else begin
          vis_we     = 1'b1;
          vis_waddr  = addr_of(IX_W'(v_q));
          byp_vld_d  = 1'b1;
          byp_addr_d = addr_of(IX_W'(v_q));
          mn_d       = ((len_q == '0) || (v_q < mn_q)) ? v_q : mn_q;
          sum_d      = sum_q + SUM_W'(v_q);
          len_d      = len_q + CNT_W'(1);
          v_d        = perm_rdata;
          rd_en      = 1'b1;
          raddr      = addr_of(IX_W'(perm_rdata));
        end
      end
      S_MUL: begin
        vis_we = 1'b1;
        if (len_q == '0) begin
          if (i_q == cnt_q) begin
            state_d = S_FIN;
          end else begin
            i_d     = i_q + CNT_W'(1);
            state_d = S_SCAN_RD;
          end
        end else begin
          prod_d  = PROD_W'(lm1) * PROD_W'(mn_q);
          state_d = S_COST;
        end
      end
      S_COST: begin
        cp_d    = ((mn_q != VAL_W'(1)) && (alt < base)) ? alt : base;
        state_d = S_ACC;
      end
      S_ACC: begin
        sw_d = (sw_sum > SWS_W'(SWAPS_MAX)) ? SWAPS_MAX : sw_sum[SWAPS_W-1:0];
        co_d = (co_sum > COS_W'(COST_MAX)) ? COST_MAX : co_sum[COST_W-1:0];
        if (i_q == cnt_q) begin
          state_d = S_FIN;
        end else begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_data_d.min_swaps = sw_q;
          out_data_d.min_cost  = co_q;
          cnt_d                = '0;
          state_d              = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      i_q         <= '0;
      v_q         <= '0;
      len_q       <= '0;
      mn_q        <= '0;
      sum_q       <= '0;
      prod_q      <= '0;
      cp_q        <= '0;
      sw_q        <= '0;
      co_q        <= '0;
      byp_vld_q   <= 1'b0;
      byp_addr_q  <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      v_q         <= v_d;
      len_q       <= len_d;
      mn_q        <= mn_d;
      sum_q       <= sum_d;
      prod_q      <= prod_d;
      cp_q        <= cp_d;
      sw_q        <= sw_d;
      co_q        <= co_d;
      byp_vld_q   <= byp_vld_d;
      byp_addr_q  <= byp_addr_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign in_stall_o  = (state_q != S_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[src/pmsc_chk.sv]
// Port-level checker for the permutation minimum swap cost core, bound to the top.
// Depends on pmsc_pkg and permutation_min_swap_cost_core_assert.svh.
`default_nettype none

`include "permutation_min_swap_cost_core_assert.svh"

module pmsc_chk
  import pmsc_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire in_t  in_data_i,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_data_o
);

  `PMSC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result word changed")
  `PMSC_ASSERT_NEXT(a_last_stalls, in_valid_i && !in_stall_o && in_data_i.last, in_stall_o, "input not stalled after last word")
  `PMSC_ASSERT_NEXT(a_no_rise_on_load, in_valid_i && !in_stall_o, !$rose(out_valid_o), "result appeared while loading")
  `PMSC_ASSERT_NOW(a_zero_match, out_valid_o, (out_data_o.min_swaps == '0) == (out_data_o.min_cost == '0), "swap count and cost disagree on zero")
  `PMSC_ASSERT_NOW(a_cost_bound, out_valid_o, out_data_o.min_cost >= COST_W'(out_data_o.min_swaps), "cost below swap count")

endmodule

bind permutation_min_swap_cost_core pmsc_chk u_chk (.*);

`default_nettype wire

[sim/pmsc_sort_cost_checker.sv]
// Checker for the permutation minimum swap cost core: watches both word channels,
// predicts each set's swap count and cost, and compares. Depends on pmsc_pkg.
`timescale 1ns / 1ps

module pmsc_sort_cost_checker
  import pmsc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_stall_i,
  input  wire in_t  in_data_i,
  input  wire logic out_valid_i,
  input  wire logic out_stall_i,
  input  wire out_t out_data_i,
  output int        fails_o,
  output int        pending_o
);

  logic [VAL_W-1:0] perm_q [1:MAX_ELEMENTS];
  int unsigned      held;
  out_t             sort_cost_q [$];

  function automatic out_t sort_cost(input int unsigned n);
    bit              seen [1:MAX_ELEMENTS];
    longint unsigned swaps, cost, sum, len, lo, cp, alt;
    int unsigned     i, cur, v;
    out_t            r;
    swaps = 0;
    cost  = 0;
    for (i = 1; i <= n; i++) begin
      if (!seen[i]) begin
        if (perm_q[i] != i) begin
          sum = 0;
          len = 0;
          lo  = 0;
          cur = i;
          forever begin
            v = perm_q[cur];
            if (v == 0 || v > n || seen[v]) break;
            if (len == 0 || v < lo) lo = v;
            sum += v;
            seen[v] = 1'b1;
            cur = v;
            len++;
          end
          if (len > 0) begin
            cp = (len - 1) * lo + sum - lo;
            // borrowing element 1 may be cheaper
            if (lo != 1) begin
              alt = sum + lo + len + 1;
              if (alt < cp) cp = alt;
            end
            swaps = swaps + len - 1;
            if (swaps > SWAPS_MAX) swaps = SWAPS_MAX;
            cost = cost + cp;
            if (cost > COST_MAX) cost = COST_MAX;
          end
        end
        seen[i] = 1'b1;
      end
    end
    r.min_swaps = swaps[SWAPS_W-1:0];
    r.min_cost  = cost[COST_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    if (!rst_ni) begin
      held = 0;
      sort_cost_q.delete();
      fails_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        // words past the store size are dropped
        if (held < MAX_ELEMENTS) begin
          held++;
          perm_q[held] = in_data_i.value;
        end
        if (in_data_i.last) begin
          sort_cost_q.push_back(sort_cost(held));
          held = 0;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (sort_cost_q.size() == 0) begin
          $display("%0t: unexpected result word, swaps %0d cost %0d", $time,
                   out_data_i.min_swaps, out_data_i.min_cost);
          fails_o++;
        end else begin
          want = sort_cost_q.pop_front();
          if (out_data_i.min_swaps !== want.min_swaps) begin
            $display("%0t: min_swaps expected %0d, got %0d", $time,
                     want.min_swaps, out_data_i.min_swaps);
            fails_o++;
          end
          if (out_data_i.min_cost !== want.min_cost) begin
            $display("%0t: min_cost expected %0d, got %0d", $time,
                     want.min_cost, out_data_i.min_cost);
            fails_o++;
          end
        end
      end
    end
    pending_o = sort_cost_q.size();
  end

endmodule

[sim/tb_permutation_min_swap_cost_core.sv]
// Testbench top for the permutation minimum swap cost core: drives sets of words
// with random idling and gives the verdict. Depends on pmsc_pkg and pmsc_sort_cost_checker.
`timescale 1ns / 1ps

module tb_permutation_min_swap_cost_core;
  import pmsc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  logic in_fire = 1'b0;
  int   fails;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   words_sent;
  int   sets_sent;

  logic [VAL_W-1:0] set_q [$];

  permutation_min_swap_cost_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  pmsc_sort_cost_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    in_fire <= in_valid_i && !in_stall_o;
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    #10000000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_word(input logic [VAL_W-1:0] v, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{value: v, last: l};
    do @(negedge clk_i); while (!in_fire);
    words_sent++;
  endtask

  task automatic send_set();
    int k;
    for (k = 0; k < set_q.size(); k++) begin
      send_word(set_q[k], k == set_q.size() - 1);
    end
    sets_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic void make_perm(input int n);
    int               k, j;
    logic [VAL_W-1:0] t;
    set_q.delete();
    for (k = 1; k <= n; k++) set_q.push_back(VAL_W'(k));
    for (k = n - 1; k > 0; k--) begin
      j        = $urandom_range(k);
      t        = set_q[k];
      set_q[k] = set_q[j];
      set_q[j] = t;
    end
  endfunction

  // mostly shuffled permutations, some corrupted, some pure noise
  task automatic random_sets(input int words);
    int target, n, kind, k;
    target = words_sent + words;
    while (words_sent < target) begin
      n    = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
      kind = $urandom_range(99);
      make_perm(n);
      if (kind >= 70 && kind < 88) begin
        repeat ($urandom_range(3, 1)) begin
          set_q[$urandom_range(n - 1)] = VAL_W'($urandom_range(n + 1));
        end
      end else if (kind >= 88) begin
        for (k = 0; k < n; k++) set_q[k] = VAL_W'($urandom_range(2047));
      end
      send_set();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    send_idle_pct = 26;
    recv_idle_pct = 52;
    words_sent    = 0;
    sets_sent     = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_q = '{11'd1};
    send_set();
    set_q = '{11'd0};
    send_set();
    set_q = '{11'd2047};
    send_set();
    set_q = '{11'd2, 11'd1};
    send_set();
    set_q = '{11'd3, 11'd1, 11'd2};
    send_set();
    set_q = '{11'd1024, 11'd2047, 11'd0};
    send_set();
    set_q = '{11'd2, 11'd2, 11'd2};
    send_set();
    // cycle of six with minimum 3, cheaper via element 1
    set_q = '{11'd1, 11'd2, 11'd4, 11'd5, 11'd6, 11'd7, 11'd8, 11'd3};
    send_set();

    random_sets(125);
    drain();

    send_idle_pct = 52;
    recv_idle_pct = 26;
    random_sets(125);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_sets(135);
    drain();

    repeat (40) @(negedge clk_i);

    $display("Ran %0d words in %0d sets: corner words, shuffled, corrupted and noise sets,",
             words_sent, sets_sent);
    $display("under varied idling, with pauses until every result word had arrived.");
    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
